[design/sbd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared sizes, codes and control structs of the sequence break detector.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam int SMALL_AW         = 10;
  localparam int LARGE_AW         = 9;
  localparam int BUCKET_AW        = 8;
  localparam int SMALL_COUNTERS   = 1 << SMALL_AW;
  localparam int LARGE_COUNTERS   = 1 << LARGE_AW;
  localparam int BUCKETS          = 1 << BUCKET_AW;
  localparam int CELLS_PER_BUCKET = 4;
  localparam int POS_W            = $clog2(CELLS_PER_BUCKET);

  localparam int SEQ_W   = 32;
  localparam int ROW_W   = SEQ_W * CELLS_PER_BUCKET;
  localparam int SMALL_W = 2;
  localparam int LARGE_W = 4;

  // Clearing pass walks the deepest store; shallower ones take the low bits.
  localparam int CLR_AW = (SMALL_AW > LARGE_AW) ?
                          ((SMALL_AW > BUCKET_AW) ? SMALL_AW : BUCKET_AW) :
                          ((LARGE_AW > BUCKET_AW) ? LARGE_AW : BUCKET_AW);

  localparam logic [SMALL_W-1:0] SMALL_SAT = '1;
  localparam logic [LARGE_W-1:0] LARGE_SAT = '1;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    CODE_NONE  = 2'd0,
    CODE_NEAR  = 2'd1,
    CODE_BREAK = 2'd2,
    CODE_EVICT = 2'd3
  } bucket_code_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MODE      = 2'd1,
    REG_NEAR_MAX  = 2'd2,
    REG_BREAK_LIM = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]  count_threshold;
    logic        judge_mode;
    logic [7:0]  near_gap_max;
    logic [15:0] break_gap_limit;
  } cfg_t;

  typedef struct packed {
    logic clear;  // write zeros at the sweep address
    logic load;   // capture input item, launch memory reads
    logic exec;   // update stores, load result
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

endpackage
`default_nettype wire

[design/sbd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/sbd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_ctrl
// Controller: clearing pass, item handshake and read/update sequencing.
// ----------------------------------------------------------------------------
module sbd_ctrl import sbd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   accept;

  // Take an item only when the result slot is free by the time it is loaded.
  assign in_stall = !((state == ST_IDLE) && (!out_valid || !out_stall));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd.clear = (state == ST_CLEAR);
    cmd.load  = accept;
    cmd.exec  = (state == ST_EXEC);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (state == ST_EXEC) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

[design/sbd_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_datapath
// Counter and bucket memories, conservative update, query and bucket match.
// ----------------------------------------------------------------------------
module sbd_datapath import sbd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  input  wire logic [SEQ_W-1:0]     seq_num,
  input  wire logic [SMALL_AW-1:0]  small_index,
  input  wire logic [LARGE_AW-1:0]  large_index,
  input  wire logic [BUCKET_AW-1:0] bucket_index,
  output logic                      break_flag,
  output logic [LARGE_W-1:0]        flow_estimate,
  output logic [1:0]                bucket_code
);

  logic [SEQ_W-1:0]     seq_r;
  logic [SMALL_AW-1:0]  si_r;
  logic [LARGE_AW-1:0]  li_r;
  logic [BUCKET_AW-1:0] bi_r;
  logic [CLR_AW-1:0]    clr_addr;

  logic [SMALL_W-1:0] small_rdata, small_wdata, r2, n2;
  logic [LARGE_W-1:0] large_rdata, large_wdata, r4, n4, est;
  logic [ROW_W-1:0]   row_rdata, row_new, row_wdata;
  logic               consult, bucket_we;

  logic [SMALL_AW-1:0]  small_waddr;
  logic [LARGE_AW-1:0]  large_waddr;
  logic [BUCKET_AW-1:0] bucket_waddr;

  logic [SEQ_W-1:0]            slot_seq [CELLS_PER_BUCKET];
  logic [SEQ_W-1:0]            gap      [CELLS_PER_BUCKET];
  logic [CELLS_PER_BUCKET-1:0] near_hit, brk_hit;
  logic [POS_W-1:0]            near_pos, brk_pos, pos;
  bucket_code_t                code;
  logic                        flag;

  // Capture item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seq_r <= seq_num;
      si_r  <= small_index;
      li_r  <= large_index;
      bi_r  <= bucket_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign stat.clear_last = (clr_addr == '1);

  // Conservative update
  assign r2 = small_rdata;
  assign r4 = large_rdata;

  always_comb begin
    n2 = r2;
    n4 = r4;
    if (r2 == SMALL_SAT && r4 == LARGE_SAT) begin
      n2 = r2;
    end else if (r2 == SMALL_SAT || (r4 != LARGE_SAT && LARGE_W'(r2) > r4)) begin
      n4 = r4 + 1'b1;
    end else if (r4 == LARGE_SAT || LARGE_W'(r2) < r4) begin
      n2 = r2 + 1'b1;
    end else begin
      n2 = r2 + 1'b1;
      n4 = r4 + 1'b1;
    end
  end

  always_comb begin
    if (n2 == SMALL_SAT) begin
      est = n4;
    end else if (LARGE_W'(n2) < n4) begin
      est = LARGE_W'(n2);
    end else begin
      est = n4;
    end
  end

  assign consult = (est > cfg.count_threshold);

  // Gap tests on every cell in parallel
  always_comb begin
    for (int c = 0; c < CELLS_PER_BUCKET; c++) begin
      slot_seq[c] = row_rdata[c*SEQ_W +: SEQ_W];
      gap[c]      = seq_r - slot_seq[c];
      near_hit[c] = (gap[c] != '0) && (gap[c] <= SEQ_W'(cfg.near_gap_max));
      brk_hit[c]  = (gap[c] > SEQ_W'(cfg.near_gap_max)) &&
                    (gap[c] < SEQ_W'(cfg.break_gap_limit));
    end
  end

  // First matching cell wins: scan downward so the lowest index is kept
  always_comb begin
    near_pos = '0;
    brk_pos  = '0;
    for (int c = CELLS_PER_BUCKET - 1; c >= 0; c--) begin
      if (near_hit[c]) near_pos = POS_W'(c);
      if (brk_hit[c])  brk_pos  = POS_W'(c);
    end
  end

  always_comb begin
    if (!consult) begin
      code = CODE_NONE;
      pos  = POS_W'(CELLS_PER_BUCKET - 1);
    end else if (|near_hit) begin
      code = CODE_NEAR;
      pos  = near_pos;
    end else if (|brk_hit) begin
      code = CODE_BREAK;
      pos  = brk_pos;
    end else begin
      code = CODE_EVICT;
      pos  = POS_W'(CELLS_PER_BUCKET - 1);
    end
  end

  always_comb begin
    if (!consult) begin
      flag = 1'b0;
    end else if (cfg.judge_mode) begin
      flag = (code != CODE_NEAR);
    end else begin
      flag = (code == CODE_BREAK);
    end
  end

  // Promote: shift cells up to pos back by one, new number at the front
  always_comb begin
    row_new = row_rdata;
    row_new[0 +: SEQ_W] = seq_r;
    for (int i = 1; i < CELLS_PER_BUCKET; i++) begin
      if (POS_W'(i) <= pos) begin
        row_new[i*SEQ_W +: SEQ_W] = slot_seq[i-1];
      end
    end
  end

  // Write port: sweep zeros while clearing, else write back the update
  always_comb begin
    small_waddr  = cmd.clear ? clr_addr[SMALL_AW-1:0]  : si_r;
    large_waddr  = cmd.clear ? clr_addr[LARGE_AW-1:0]  : li_r;
    bucket_waddr = cmd.clear ? clr_addr[BUCKET_AW-1:0] : bi_r;
    small_wdata  = cmd.clear ? '0 : n2;
    large_wdata  = cmd.clear ? '0 : n4;
    row_wdata    = cmd.clear ? '0 : row_new;
    bucket_we    = cmd.clear || (cmd.exec && consult);
  end

  sbd_ram #(.WIDTH(SMALL_W), .DEPTH(SMALL_COUNTERS)) u_small_ram (
    .clk   (clk),
    .we    (cmd.clear || cmd.exec),
    .waddr (small_waddr),
    .wdata (small_wdata),
    .raddr (small_index),
    .rdata (small_rdata)
  );

  sbd_ram #(.WIDTH(LARGE_W), .DEPTH(LARGE_COUNTERS)) u_large_ram (
    .clk   (clk),
    .we    (cmd.clear || cmd.exec),
    .waddr (large_waddr),
    .wdata (large_wdata),
    .raddr (large_index),
    .rdata (large_rdata)
  );

  sbd_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_bucket_ram (
    .clk   (clk),
    .we    (bucket_we),
    .waddr (bucket_waddr),
    .wdata (row_wdata),
    .raddr (bucket_index),
    .rdata (row_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      break_flag    <= flag;
      flow_estimate <= est;
      bucket_code   <= code;
    end
  end

endmodule
`default_nettype wire

[design/sequence_break_detector_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequence_break_detector_core
// Flow break detector over a two-layer count sketch and sequence buckets.
// ----------------------------------------------------------------------------
// Each item takes a read step and an update step: the accepting cycle reads
// the 2-bit counter, the 4-bit counter and the bucket row from their memories,
// and the EXEC state updates them and loads the result. The single
// read-modify-write on each memory keeps a new item out until the last is
// through. After reset the block sweeps all memories to zero and holds
// in_stall high meanwhile; register writes are taken at any time.
// ----------------------------------------------------------------------------
module sequence_break_detector_core import sbd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_W-1:0]    paddr,
  input  wire logic [DATA_W-1:0]    pwdata,
  output logic      [DATA_W-1:0]    prdata,
  output logic                      pready,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [SEQ_W-1:0]     seq_num,
  input  wire logic [SMALL_AW-1:0]  small_index,
  input  wire logic [LARGE_AW-1:0]  large_index,
  input  wire logic [BUCKET_AW-1:0] bucket_index,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      break_flag,
  output logic [LARGE_W-1:0]        flow_estimate,
  output logic [1:0]                bucket_code
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  reg_idx_t reg_idx;
  logic     reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_threshold <= 4'd14;
      cfg.judge_mode      <= 1'b0;
      cfg.near_gap_max    <= 8'd3;
      cfg.break_gap_limit <= 16'd50;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_THRESHOLD: cfg.count_threshold <= pwdata[3:0];
        REG_MODE:      cfg.judge_mode      <= pwdata[0];
        REG_NEAR_MAX:  cfg.near_gap_max    <= pwdata[7:0];
        REG_BREAK_LIM: cfg.break_gap_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = DATA_W'(cfg.count_threshold);
      REG_MODE:      prdata = DATA_W'(cfg.judge_mode);
      REG_NEAR_MAX:  prdata = DATA_W'(cfg.near_gap_max);
      REG_BREAK_LIM: prdata = DATA_W'(cfg.break_gap_limit);
      default:       prdata = '0;
    endcase
  end

  sbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sbd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .stat          (stat),
    .seq_num       (seq_num),
    .small_index   (small_index),
    .large_index   (large_index),
    .bucket_index  (bucket_index),
    .break_flag    (break_flag),
    .flow_estimate (flow_estimate),
    .bucket_code   (bucket_code)
  );

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> ##1 out_valid)
    else $error("accepted item produced no result two cycles later");

  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without an accepted item");

  a_no_flag_unconsulted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bucket_code == CODE_NONE) |-> !break_flag)
    else $error("break flagged without consulting the bucket");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while previous item in progress");

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sequence break detector: a directed table, then
// random packet flows over several register settings, checked item by item
// against a behavioral sketch and bucket model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top import sbd_pkg::*; ();

  localparam int unsigned LIMIT_CYCLES   = 400_000;
  localparam int          N_PROBES       = 15;
  localparam int          N_PHASES       = 6;
  localparam int          ITEMS_PER_PHASE = 125;

  typedef struct packed {
    logic         flag;
    logic [3:0]   est;
    bucket_code_t code;
  } verdict_t;

  typedef struct packed {
    logic [SEQ_W-1:0]     seq;
    logic [SMALL_AW-1:0]  si;
    logic [LARGE_AW-1:0]  li;
    logic [BUCKET_AW-1:0] bi;
    logic [4:0]           reps;   // resend with seq advancing by one
    logic                 typed;  // use the typed-in verdict below
    verdict_t             want;
  } probe_row_t;

  typedef struct packed {
    logic [3:0]  thr;
    logic        mode;
    logic [7:0]  near_max;
    logic [15:0] brk_lim;
    logic [6:0]  src_pct;
    logic [6:0]  rcv_pct;
  } phase_row_t;

  // Directed part runs with threshold 0, mode 0, near max 3, break limit 50.
  probe_row_t probe_rows [N_PROBES] = '{
    '{32'd0,          10'd0,    9'd0,   8'd0,   5'd1,  1'b1, '{1'b0, 4'd1, CODE_EVICT}},
    '{32'd2,          10'd0,    9'd0,   8'd0,   5'd1,  1'b1, '{1'b0, 4'd2, CODE_NEAR}},
    '{32'd20,         10'd0,    9'd0,   8'd0,   5'd1,  1'b1, '{1'b1, 4'd3, CODE_BREAK}},
    '{32'hFFFF_FFFF,  10'd1023, 9'd511, 8'd255, 5'd1,  1'b1, '{1'b0, 4'd1, CODE_EVICT}},
    '{32'd1,          10'd1023, 9'd511, 8'd255, 5'd1,  1'b1, '{1'b0, 4'd2, CODE_NEAR}},
    '{32'd23,         10'd5,    9'd5,   8'd0,   5'd1,  1'b0, '{1'b0, 4'd0, CODE_NONE}},
    '{32'd27,         10'd5,    9'd5,   8'd0,   5'd1,  1'b0, '{1'b0, 4'd0, CODE_NONE}},
    '{32'd76,         10'd6,    9'd6,   8'd0,   5'd1,  1'b0, '{1'b0, 4'd0, CODE_NONE}},
    '{32'd126,        10'd6,    9'd6,   8'd0,   5'd1,  1'b0, '{1'b0, 4'd0, CODE_NONE}},
    '{32'd78,         10'd6,    9'd6,   8'd0,   5'd1,  1'b0, '{1'b0, 4'd0, CODE_NONE}},
    '{32'd130,        10'd6,    9'd6,   8'd0,   5'd1,  1'b0, '{1'b0, 4'd0, CODE_NONE}},
    '{32'd1000,       10'd7,    9'd9,   8'd3,   5'd16, 1'b0, '{1'b0, 4'd0, CODE_NONE}},
    '{32'd5000,       10'd7,    9'd20,  8'd3,   5'd1,  1'b0, '{1'b0, 4'd0, CODE_NONE}},
    '{32'd5001,       10'd8,    9'd9,   8'd3,   5'd1,  1'b0, '{1'b0, 4'd0, CODE_NONE}},
    '{32'd5002,       10'd5,    9'd21,  8'd3,   5'd1,  1'b0, '{1'b0, 4'd0, CODE_NONE}}
  };

  phase_row_t phase_rows [N_PHASES] = '{
    '{4'd0,  1'b1, 8'd3,   16'd50,    7'd31, 7'd86},
    '{4'd15, 1'b0, 8'd255, 16'd65535, 7'd31, 7'd86},
    '{4'd3,  1'b1, 8'd0,   16'd2,     7'd86, 7'd31},
    '{4'd7,  1'b0, 8'd255, 16'd2,     7'd86, 7'd31},
    '{4'd1,  1'b1, 8'd1,   16'd65535, 7'd0,  7'd0},
    '{4'd14, 1'b0, 8'd3,   16'd50,    7'd0,  7'd0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [SEQ_W-1:0]     seq_num = '0;
  logic [SMALL_AW-1:0]  small_index = '0;
  logic [LARGE_AW-1:0]  large_index = '0;
  logic [BUCKET_AW-1:0] bucket_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 break_flag;
  logic [LARGE_W-1:0]   flow_estimate;
  logic [1:0]           bucket_code;

  // bench copy of the block state
  logic [SMALL_W-1:0] small_sketch [SMALL_COUNTERS] = '{default: '0};
  logic [LARGE_W-1:0] large_sketch [LARGE_COUNTERS] = '{default: '0};
  logic [SEQ_W-1:0]   seq_cells [BUCKETS][CELLS_PER_BUCKET] = '{default: '0};
  cfg_t               shadow_cfg = '{count_threshold: 4'd14, judge_mode: 1'b0,
                                     near_gap_max: 8'd3, break_gap_limit: 16'd50};

  verdict_t    pending_verdicts [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;

  sequence_break_detector_core dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .seq_num       (seq_num),
    .small_index   (small_index),
    .large_index   (large_index),
    .bucket_index  (bucket_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .break_flag    (break_flag),
    .flow_estimate (flow_estimate),
    .bucket_code   (bucket_code)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  // Conservative update of both counters, query, then bucket lookup.
  function automatic verdict_t sketch_verdict(input logic [SEQ_W-1:0] seq,
                                              input logic [SMALL_AW-1:0] si,
                                              input logic [LARGE_AW-1:0] li,
                                              input logic [BUCKET_AW-1:0] bi);
    logic [SMALL_W-1:0] c2;
    logic [LARGE_W-1:0] c4;
    logic [SEQ_W-1:0]   gap;
    int                 hit;
    int                 c;
    verdict_t           v;
    c2 = small_sketch[si];
    c4 = large_sketch[li];
    if (!(c2 == SMALL_SAT && c4 == LARGE_SAT)) begin
      if (c2 == SMALL_SAT || (c4 != LARGE_SAT && c2 > c4)) begin
        c4 = c4 + 1'b1;
      end else if (c4 == LARGE_SAT || c2 < c4) begin
        c2 = c2 + 1'b1;
      end else begin
        c2 = c2 + 1'b1;
        c4 = c4 + 1'b1;
      end
    end
    small_sketch[si] = c2;
    large_sketch[li] = c4;
    v.est  = (c2 == SMALL_SAT) ? c4 : ((c2 < c4) ? {2'b00, c2} : c4);
    v.flag = 1'b0;
    v.code = CODE_NONE;
    if (v.est > shadow_cfg.count_threshold) begin
      hit = -1;
      for (c = 0; c < CELLS_PER_BUCKET; c++) begin
        gap = seq - seq_cells[bi][c];
        if (hit < 0 && gap >= 1 && gap <= shadow_cfg.near_gap_max) begin
          hit    = c;
          v.code = CODE_NEAR;
        end
      end
      for (c = 0; c < CELLS_PER_BUCKET; c++) begin
        gap = seq - seq_cells[bi][c];
        if (hit < 0 && gap > shadow_cfg.near_gap_max && gap < shadow_cfg.break_gap_limit) begin
          hit    = c;
          v.code = CODE_BREAK;
        end
      end
      if (hit < 0) begin
        hit    = CELLS_PER_BUCKET - 1;
        v.code = CODE_EVICT;
      end
      // move the hit cell to the front and overwrite it with the new number
      for (c = hit; c > 0; c--)
        seq_cells[bi][c] = seq_cells[bi][c-1];
      seq_cells[bi][0] = seq;
      v.flag = shadow_cfg.judge_mode ? (v.code != CODE_NEAR) : (v.code == CODE_BREAK);
    end
    return v;
  endfunction

  task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    logic ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      rdata = prdata;
      @(posedge clk);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write one register, mirror it, and read it back.
  task automatic set_register(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] rdata;
    logic [31:0] want;
    logic [31:0] mask;
    apb_access(1'b1, idx, value, rdata);
    case (idx)
      REG_THRESHOLD: begin
        shadow_cfg.count_threshold = value[3:0];
        want = {28'd0, value[3:0]};
        mask = 32'h0000_000F;
      end
      REG_MODE: begin
        shadow_cfg.judge_mode = value[0];
        want = {31'd0, value[0]};
        mask = 32'h0000_0001;
      end
      REG_NEAR_MAX: begin
        shadow_cfg.near_gap_max = value[7:0];
        want = {24'd0, value[7:0]};
        mask = 32'h0000_00FF;
      end
      default: begin
        shadow_cfg.break_gap_limit = value[15:0];
        want = {16'd0, value[15:0]};
        mask = 32'h0000_FFFF;
      end
    endcase
    apb_access(1'b0, idx, 32'd0, rdata);
    if ((rdata & mask) !== want)
      report_mismatch($sformatf("register %s readback", idx.name()), want, rdata);
  endtask

  // Present one item, hold it until taken, then queue its expected verdict.
  task automatic offer_packet(input logic [SEQ_W-1:0] seq, input logic [SMALL_AW-1:0] si,
                              input logic [LARGE_AW-1:0] li, input logic [BUCKET_AW-1:0] bi,
                              input logic typed, input verdict_t typed_v);
    logic     taken;
    verdict_t v;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    seq_num      <= seq;
    small_index  <= si;
    large_index  <= li;
    bucket_index <= bi;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    v = sketch_verdict(seq, si, li, bi);
    if (typed)
      v = typed_v;
    pending_verdicts = {pending_verdicts, v};
  endtask

  task automatic drain_results();
    while (pending_verdicts.size() != 0)
      @(posedge clk);
    // the block is idle once its last result is out; the repeat below is only a margin
    repeat (4) @(posedge clk);
  endtask

  // Results are sampled mid-cycle and taken at the following edge.
  always @(negedge clk) begin : result_check
    verdict_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result", 32'd0,
                        {25'd0, break_flag, flow_estimate, bucket_code});
      end else begin
        want = pending_verdicts.pop_front();
        if (break_flag !== want.flag)
          report_mismatch("break_flag", 32'(want.flag), 32'(break_flag));
        if (flow_estimate !== want.est)
          report_mismatch("flow_estimate", 32'(want.est), 32'(flow_estimate));
        if (bucket_code !== want.code)
          report_mismatch("bucket_code", 32'(want.code), 32'(bucket_code));
      end
    end
  end

  initial begin : stimulus
    logic [SMALL_AW-1:0]  hot_si [4];
    logic [LARGE_AW-1:0]  hot_li [4];
    logic [BUCKET_AW-1:0] hot_bi [4];
    logic [SEQ_W-1:0]     flow_seq [4];
    logic [SEQ_W-1:0]     seq;
    logic [SMALL_AW-1:0]  si;
    logic [LARGE_AW-1:0]  li;
    logic [BUCKET_AW-1:0] bi;
    int                   k;
    int                   p;
    int                   n;
    int                   r;

    for (k = 0; k < 4; k++) begin
      hot_si[k]   = SMALL_AW'($urandom_range(0, SMALL_COUNTERS - 1));
      hot_li[k]   = LARGE_AW'($urandom_range(0, LARGE_COUNTERS - 1));
      hot_bi[k]   = BUCKET_AW'($urandom_range(0, BUCKETS - 1));
      flow_seq[k] = $urandom;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 31;
    rcv_idle_pct = 86;
    set_register(REG_THRESHOLD, 32'd0);
    set_register(REG_MODE, 32'd0);
    set_register(REG_NEAR_MAX, 32'd3);
    set_register(REG_BREAK_LIM, 32'd50);

    foreach (probe_rows[i]) begin
      for (r = 0; r < probe_rows[i].reps; r++)
        offer_packet(probe_rows[i].seq + r, probe_rows[i].si, probe_rows[i].li,
                     probe_rows[i].bi, probe_rows[i].typed, probe_rows[i].want);
    end
    in_valid <= 1'b0;
    drain_results();

    for (p = 0; p < N_PHASES; p++) begin
      src_idle_pct = 32'(phase_rows[p].src_pct);
      rcv_idle_pct = 32'(phase_rows[p].rcv_pct);
      set_register(REG_THRESHOLD, {28'd0, phase_rows[p].thr});
      set_register(REG_MODE, {31'd0, phase_rows[p].mode});
      set_register(REG_NEAR_MAX, {24'd0, phase_rows[p].near_max});
      set_register(REG_BREAK_LIM, {16'd0, phase_rows[p].brk_lim});

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // mostly a few hot flows, so counters climb and buckets get consulted
        k  = $urandom_range(0, 3);
        si = ($urandom_range(0, 9) < 7) ? hot_si[k] :
             SMALL_AW'($urandom_range(0, SMALL_COUNTERS - 1));
        li = ($urandom_range(0, 9) < 7) ? hot_li[k] :
             LARGE_AW'($urandom_range(0, LARGE_COUNTERS - 1));
        bi = ($urandom_range(0, 9) < 8) ? hot_bi[k] :
             BUCKET_AW'($urandom_range(0, BUCKETS - 1));
        case ($urandom_range(0, 9))
          0, 1, 2, 3: seq = flow_seq[k] + $urandom_range(1, 4);
          4, 5:       seq = flow_seq[k] + $urandom_range(3, 70);
          6:          seq = flow_seq[k] - $urandom_range(0, 8);
          7:          seq = flow_seq[k] + $urandom_range(250, 300);
          8:          seq = flow_seq[k] + $urandom_range(65000, 66000);
          default:    seq = $urandom;
        endcase
        flow_seq[k] = seq;
        offer_packet(seq, si, li, bi, 1'b0, '{1'b0, 4'd0, CODE_NONE});
      end
      in_valid <= 1'b0;
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
